// ===== hdl/lz4_block_decoder_defines.svh =====
// Assertion macros shared by the decoder RTL
`ifndef LZ4_BLOCK_DECODER_DEFINES_SVH
`define LZ4_BLOCK_DECODER_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/lzd_pkg.sv =====
// ---------------------------------------------------------------------------
// lzd_pkg: shared types and constants of the LZ4 block decoder
// Parse phase codes, status codes, register indexes and the stage record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package lzd_pkg;
	localparam int WinBytes = 65536;
	localparam int WinAw = $clog2(WinBytes);

	typedef enum logic [2:0] {
		PH_TOKEN = 3'd0, PH_LITEXT = 3'd1, PH_LIT = 3'd2, PH_OFF0 = 3'd3,
		PH_OFF1 = 3'd4, PH_MEXT = 3'd5, PH_MATCH = 3'd6, PH_SPARE = 3'd7
	} phase_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_BADOFF = 2'd2;

	localparam logic REG_INPUT_LENGTH = 1'b0;
	localparam logic REG_OUTPUT_CAPACITY = 1'b1;

	// Result item handed from the core to the output stage
	typedef struct packed {
		logic        out_valid;
		logic        from_mem;
		logic [7:0]  lit_byte;
		logic        consumed;
		logic        done_res;
		logic [1:0]  status;
		logic [31:0] out_count;
	} result_t;
endpackage

// ===== hdl/lzd_ram.sv =====
// ---------------------------------------------------------------------------
// lzd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lzd_ram #(
	parameter int Width = 8,
	parameter int Depth = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/lzd_core.sv =====
// ---------------------------------------------------------------------------
// lzd_core: parser and sequencer of the LZ4 block decoder
// Settles the parse state, takes at most one item per cycle and drives the
// history.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lzd_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    action,
	input  logic [7:0]              in_byte,
	input  logic [31:0]             input_length,
	input  logic [31:0]             output_capacity,
	input  logic [7:0]              hist_q,
	output logic                    hist_we,
	output logic [lzd_pkg::WinAw-1:0] hist_waddr,
	output logic [7:0]              hist_wdata,
	output logic [lzd_pkg::WinAw-1:0] hist_raddr,
	output lzd_pkg::result_t        res
);
	lzd_pkg::phase_t phase_q;
	logic [31:0] ipos_q, opos_q, plen_q;
	logic [3:0]  mnib_q;
	logic [15:0] dist_q;
	logic        fin_q;
	logic [1:0]  err_q;

	// Derived bounds
	logic [31:0] litext_lim, mext_lim;
	assign litext_lim = (input_length >= 32'd15) ? input_length - 32'd15 : 32'd0;
	assign mext_lim = (input_length >= 32'd6) ? input_length - 32'd6 : 32'd0;

	typedef struct packed {
		lzd_pkg::phase_t ph;
		logic [31:0] plen;
		logic        fin;
		logic [1:0]  err;
	} sv_t;

	function automatic sv_t settle(sv_t s, logic [31:0] ip, logic [31:0] op,
			logic [31:0] ilen, logic [31:0] cap, logic [31:0] l15, logic [31:0] l6);
		sv_t r;
		r = s;
		// at most two hops: lit->off0, match->token
		for (int g = 0; g < 2; g++) begin
			if (!r.fin) begin
				unique case (r.ph)
					lzd_pkg::PH_LITEXT: begin
						if (ip >= l15) begin r.fin = 1'b1; r.err = lzd_pkg::ST_TRUNC; end
					end
					lzd_pkg::PH_LIT: begin
						if (r.plen != 32'd0) begin
							if (ip >= ilen || op >= cap) begin
								r.fin = 1'b1; r.err = lzd_pkg::ST_OK;
							end
						end else if (ip >= ilen || (ilen - ip) <= 32'd2) begin
							r.fin = 1'b1; r.err = lzd_pkg::ST_OK;
						end else begin
							r.ph = lzd_pkg::PH_OFF0;
						end
					end
					lzd_pkg::PH_OFF0, lzd_pkg::PH_OFF1: begin
						if (ip >= ilen) begin r.fin = 1'b1; r.err = lzd_pkg::ST_TRUNC; end
					end
					lzd_pkg::PH_MEXT: begin
						if (ip >= l6) begin r.fin = 1'b1; r.err = lzd_pkg::ST_TRUNC; end
					end
					lzd_pkg::PH_MATCH: begin
						if (op >= cap) begin
							r.fin = 1'b1; r.err = lzd_pkg::ST_OK;
						end else if (r.plen == 32'd0) begin
							r.ph = lzd_pkg::PH_TOKEN;
						end
					end
					default: begin
						r.ph = lzd_pkg::PH_TOKEN;
						if (ip >= ilen) begin r.fin = 1'b1; r.err = lzd_pkg::ST_OK; end
					end
				endcase
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	sv_t s0, s1, s2;
	logic [31:0] ip_n, op_n;
	logic [3:0]  mnib_n;
	logic [15:0] dist_n;
	logic        took, emit, emit_mem;
	logic [7:0]  lit_b;

	// Settle, act on the item, settle again
	always_comb begin
		s0 = '{ph: phase_q, plen: plen_q, fin: fin_q, err: err_q};
		s1 = settle(s0, ipos_q, opos_q, input_length, output_capacity, litext_lim, mext_lim);
		s2 = s1;
		ip_n = ipos_q;
		op_n = opos_q;
		mnib_n = mnib_q;
		dist_n = dist_q;
		took = 1'b0;
		emit = 1'b0;
		emit_mem = 1'b0;
		lit_b = 8'd0;
		if (!s1.fin) begin
			if (s1.ph == lzd_pkg::PH_MATCH) begin
				emit = 1'b1;
				emit_mem = 1'b1;
				op_n = opos_q + 32'd1;
				s2.plen = s1.plen - 32'd1;
			end else if (!action) begin
				took = 1'b1;
				ip_n = ipos_q + 32'd1;
				unique case (s1.ph)
					lzd_pkg::PH_LITEXT: begin
						s2.plen = sat_add(s1.plen, {24'd0, in_byte});
						if (in_byte != 8'hFF) s2.ph = lzd_pkg::PH_LIT;
					end
					lzd_pkg::PH_LIT: begin
						emit = 1'b1;
						lit_b = in_byte;
						op_n = opos_q + 32'd1;
						s2.plen = s1.plen - 32'd1;
					end
					lzd_pkg::PH_OFF0: begin
						dist_n = {8'd0, in_byte};
						s2.ph = lzd_pkg::PH_OFF1;
					end
					lzd_pkg::PH_OFF1: begin
						dist_n = {in_byte, dist_q[7:0]};
						if (dist_n == 16'd0 || {16'd0, dist_n} > opos_q) begin
							s2.fin = 1'b1;
							s2.err = lzd_pkg::ST_BADOFF;
						end else if (mnib_q == 4'd15) begin
							s2.plen = 32'd15;
							s2.ph = lzd_pkg::PH_MEXT;
						end else begin
							s2.plen = {28'd0, mnib_q} + 32'd4;
							s2.ph = lzd_pkg::PH_MATCH;
						end
					end
					lzd_pkg::PH_MEXT: begin
						s2.plen = sat_add(s1.plen, {24'd0, in_byte});
						if (in_byte != 8'hFF) begin
							s2.plen = sat_add(s2.plen, 32'd4);
							s2.ph = lzd_pkg::PH_MATCH;
						end
					end
					default: begin
						mnib_n = in_byte[3:0];
						if (in_byte[7:4] == 4'hF) begin
							s2.plen = 32'd15;
							s2.ph = lzd_pkg::PH_LITEXT;
						end else begin
							s2.plen = {28'd0, in_byte[7:4]};
							s2.ph = lzd_pkg::PH_LIT;
						end
					end
				endcase
			end
			s2 = settle(s2, ip_n, op_n, input_length, output_capacity, litext_lim, mext_lim);
		end
	end

	// History access: read the match source; literals write directly,
	// match bytes are written in the next cycle once the read data returns.
	// The step after a match byte is held meanwhile, so every read sees all
	// earlier writes and no forwarding is needed.
	logic        mwr_s1;
	logic [lzd_pkg::WinAw-1:0] maddr_s1;
	logic [7:0]  mbyte;
	assign mbyte = hist_q;
	assign hist_raddr = opos_q[lzd_pkg::WinAw-1:0] - dist_q;
	assign hist_we = mwr_s1 | (step & emit & !emit_mem);
	assign hist_waddr = mwr_s1 ? maddr_s1 : opos_q[lzd_pkg::WinAw-1:0];
	assign hist_wdata = mwr_s1 ? mbyte : lit_b;

	// Result for the output stage; match byte resolved there
	always_comb begin
		res.out_valid = emit;
		res.from_mem = emit_mem;
		res.lit_byte = lit_b;
		res.consumed = took;
		res.done_res = s1.fin ? s1.fin : s2.fin;
		res.status = s1.fin ? s1.err : s2.err;
		res.out_count = op_n;
	end

	// Hold or advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzd_pkg::PH_TOKEN;
			ipos_q <= 32'd0;
			opos_q <= 32'd0;
			plen_q <= 32'd0;
			mnib_q <= 4'd0;
			dist_q <= 16'd0;
			fin_q <= 1'b0;
			err_q <= lzd_pkg::ST_OK;
			mwr_s1 <= 1'b0;
		end else begin
			mwr_s1 <= 1'b0;
			if (step) begin
				phase_q <= s1.fin ? s1.ph : s2.ph;
				plen_q <= s1.fin ? s1.plen : s2.plen;
				fin_q <= s1.fin | s2.fin;
				err_q <= s1.fin ? s1.err : s2.err;
				ipos_q <= ip_n;
				opos_q <= op_n;
				mnib_q <= mnib_n;
				dist_q <= dist_n;
				mwr_s1 <= emit_mem;
			end
		end
	end

	// Match write address
	always_ff @(posedge clk) begin
		if (step && emit) begin
			maddr_s1 <= opos_q[lzd_pkg::WinAw-1:0];
		end
	end
endmodule

// ===== hdl/lz4_block_decoder.sv =====
// LZ4 block decoder.
// Channels: input item (action, in_byte) on in_valid/in_ready; result item
// (out_valid, out_byte, consumed, done_res, status, out_count) on
// res_valid/res_ready; register writes (cfg_index, cfg_data) on
// cfg_valid/cfg_ready, index 0 input_length, index 1 output_capacity.
// Each input item gives exactly one result item. An item is processed in
// the cycle it is accepted; its result appears in the output register in
// the next cycle, a match byte once its history read data has returned.
// Throughput is one item per cycle for literals, control bytes and idle
// ticks while the receiver keeps up. Match bytes read the history through
// the registered RAM port, so the step that follows a match byte waits for
// the read data (a match drain takes no byte before the last is written).
// Reset clears the parse state and config registers; the history is not cleared.
// When the receiver stalls, the result register holds and input is taken
// only while the register is empty or being drained.
// ---------------------------------------------------------------------------
// lz4_block_decoder: top level with output register and history RAM
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lz4_block_decoder_defines.svh"
module lz4_block_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  in_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        consumed,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [31:0] out_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] ilen_q, cap_q;
	logic        hist_we, step, rv_q, mem_pend_q;
	logic [lzd_pkg::WinAw-1:0] hist_waddr, hist_raddr;
	logic [7:0]  hist_wdata, hist_q, obyte_q;
	lzd_pkg::result_t res, res_q;

	// Take an item when the result slot frees and no match read is pending
	assign in_ready = (!rv_q || res_ready) && !mem_pend_q;
	assign step = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	lzd_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .action(action), .in_byte(in_byte),
		.input_length(ilen_q), .output_capacity(cap_q), .hist_q(hist_q),
		.hist_we(hist_we), .hist_waddr(hist_waddr), .hist_wdata(hist_wdata),
		.hist_raddr(hist_raddr), .res(res)
	);

	lzd_ram #(.Width(8), .Depth(lzd_pkg::WinBytes)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
		.re(1'b1), .raddr(hist_raddr), .rdata(hist_q)
	);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ilen_q <= 32'd0;
			cap_q <= 32'd0;
		end else if (cfg_valid) begin
			if (cfg_index == lzd_pkg::REG_INPUT_LENGTH) ilen_q <= cfg_data;
			else cap_q <= cfg_data;
		end
	end

	// Output register; a match byte arrives from the RAM in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
			mem_pend_q <= 1'b0;
		end else begin
			mem_pend_q <= step && res.from_mem;
			if (step) rv_q <= !res.from_mem;
			else if (mem_pend_q) rv_q <= 1'b1;
			else if (res_ready) rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
			obyte_q <= res.lit_byte;
		end
		if (mem_pend_q) begin
			obyte_q <= hist_wdata;
		end
	end

	assign res_valid = rv_q;
	assign out_valid = res_q.out_valid;
	assign out_byte = obyte_q;
	assign consumed = res_q.consumed;
	assign done_res = res_q.done_res;
	assign status = res_q.status;
	assign out_count = res_q.out_count;

	`LZD_ASSERT_IMPL(a_pend_blocks, clk, arst_n, mem_pend_q, !in_ready, "input taken during read")
	`LZD_ASSERT_NEXT(a_done_sticky, clk, arst_n, res_valid && done_res && step, done_res, "done cleared")
	`LZD_ASSERT_IMPL(a_status_ok, clk, arst_n, res_valid, status != 2'd3, "bad status code")
endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: regression bench for the LZ4 block decoder
// Drives well-formed LZ4 sequences with random content, idle ticks and
// random stalls on both channels. A cycle-free decoder model predicts each
// result item, and the scoreboard checks every item in order. The run closes
// with one randomly chosen way of ending the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
	import lzd_pkg::*;

	typedef struct packed {
		logic        ov;
		logic [7:0]  ob;
		logic        took;
		logic        dn;
		logic [1:0]  st;
		logic [31:0] cnt;
	} dec_res_t;

	// Decoder model plus queue of predicted result items
	class lz4_scoreboard;
		logic [31:0] in_len, out_cap, in_pos, out_pos, pend;
		phase_t      ph;
		logic [3:0]  mnib;
		logic [15:0] mdist;
		bit          fin;
		logic [1:0]  err;
		logic [7:0]  hist [0:65535];
		dec_res_t    expect_q[$];
		int          errors;
		int          items;

		function new();
			in_len = '0; out_cap = '0; in_pos = '0; out_pos = '0; pend = '0;
			ph = PH_TOKEN; mnib = '0; mdist = '0; fin = 0; err = ST_OK;
			errors = 0; items = 0;
		endfunction

		function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function logic [31:0] bound(logic [31:0] margin);
			return (in_len >= margin) ? in_len - margin : 32'd0;
		endfunction

		function void stop(logic [1:0] code);
			fin = 1;
			err = code;
		endfunction

		function void emit(logic [7:0] v);
			hist[out_pos[15:0]] = v;
			out_pos++;
		endfunction

		// Resolve every decision that needs no byte
		function void settle();
			for (int g = 0; g < 8; g++) begin
				if (fin)
					return;
				case (ph)
					PH_LITEXT: begin
						if (in_pos >= bound(15))
							stop(ST_TRUNC);
						return;
					end
					PH_LIT: begin
						if (pend != 0) begin
							if (in_pos >= in_len || out_pos >= out_cap)
								stop(ST_OK);
							return;
						end
						if (in_pos >= in_len || in_len - in_pos <= 2) begin
							stop(ST_OK);
							return;
						end
						ph = PH_OFF0;
					end
					PH_OFF0, PH_OFF1: begin
						if (in_pos >= in_len)
							stop(ST_TRUNC);
						return;
					end
					PH_MEXT: begin
						if (in_pos >= bound(6))
							stop(ST_TRUNC);
						return;
					end
					PH_MATCH: begin
						if (out_pos >= out_cap) begin
							stop(ST_OK);
							return;
						end
						if (pend != 0)
							return;
						ph = PH_TOKEN;
					end
					default: begin
						ph = PH_TOKEN;
						if (in_pos >= in_len)
							stop(ST_OK);
						return;
					end
				endcase
			end
		endfunction

		function void take(input logic [7:0] b, inout dec_res_t r);
			in_pos++;
			case (ph)
				PH_LITEXT: begin
					pend = sat_add(pend, {24'd0, b});
					if (b != 8'hFF)
						ph = PH_LIT;
				end
				PH_LIT: begin
					emit(b);
					r.ov = 1;
					r.ob = b;
					pend--;
				end
				PH_OFF0: begin
					mdist = {8'd0, b};
					ph = PH_OFF1;
				end
				PH_OFF1: begin
					mdist = {b, mdist[7:0]};
					if (mdist == 0 || {16'd0, mdist} > out_pos)
						stop(ST_BADOFF);
					else if (mnib == 4'hF) begin
						pend = 32'd15;
						ph = PH_MEXT;
					end else begin
						pend = {28'd0, mnib} + 32'd4;
						ph = PH_MATCH;
					end
				end
				PH_MEXT: begin
					pend = sat_add(pend, {24'd0, b});
					if (b != 8'hFF) begin
						pend = sat_add(pend, 32'd4);
						ph = PH_MATCH;
					end
				end
				default: begin
					mnib = b[3:0];
					pend = {28'd0, b[7:4]};
					ph = (b[7:4] == 4'hF) ? PH_LITEXT : PH_LIT;
				end
			endcase
		endfunction

		// Note an accepted input item; return whether its byte was taken
		function bit note(bit act, logic [7:0] b);
			dec_res_t r;
			logic [7:0] v;
			r = '0;
			items++;
			settle();
			if (!fin) begin
				if (ph == PH_MATCH) begin
					v = hist[16'(out_pos - {16'd0, mdist})];
					emit(v);
					r.ov = 1;
					r.ob = v;
					pend--;
				end else if (!act) begin
					r.took = 1;
					take(b, r);
				end
				settle();
			end
			r.dn = fin;
			r.st = err;
			r.cnt = out_pos;
			expect_q.push_back(r);
			return r.took;
		endfunction

		// Compare one accepted result item with the oldest prediction
		function void check(dec_res_t got);
			dec_res_t want;
			if (expect_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result item %h", got);
				return;
			end
			want = expect_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp v=%0b b=%h c=%0b d=%0b s=%0d n=%0d,",
						want.ov, want.ob, want.took, want.dn, want.st, want.cnt,
						" got v=%0b b=%h c=%0b d=%0b s=%0d n=%0d",
						got.ov, got.ob, got.took, got.dn, got.st, got.cnt);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready, action;
	logic [7:0]  in_byte;
	logic        res_valid, res_ready;
	logic        out_valid, consumed, done_res;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic [31:0] out_count;
	logic        cfg_valid, cfg_ready, cfg_index;
	logic [31:0] cfg_data;

	lz4_scoreboard sb = new();
	logic [7:0]    stream_q[$];
	int unsigned   gen_out;

	lz4_block_decoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .in_byte(in_byte),
		.res_valid(res_valid), .res_ready(res_ready),
		.out_valid(out_valid), .out_byte(out_byte), .consumed(consumed),
		.done_res(done_res), .status(status), .out_count(out_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_item(input bit act, input logic [7:0] b, input bit gaps, output bit took);
		int unsigned gap;
		gap = gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		in_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		took = sb.note(act, b);
	endtask

	// Feed the queued stream; re-offer bytes that a match drain refused
	task automatic play_stream();
		bit took;
		logic [7:0] b;
		while (stream_q.size() > 0) begin
			b = stream_q.pop_front();
			took = 0;
			while (!took && !sb.fin) begin
				if ($urandom_range(0, 9) == 0)
					send_item(1'b1, 8'($urandom), 1, took);
				send_item(1'b0, b, 1, took);
			end
		end
	endtask

	// Wait for every prediction to be met, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expect_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_INPUT_LENGTH)
			sb.in_len = data;
		else
			sb.out_cap = data;
		cfg_valid <= 1'b0;
	endtask

	// Append a length extension chain for a nibble of 15
	function void push_ext(int unsigned extra);
		while (extra >= 255) begin
			stream_q.push_back(8'hFF);
			extra -= 255;
		end
		stream_q.push_back(8'(extra));
	endfunction

	function int unsigned pick_ext();
		if ($urandom_range(0, 29) == 0)
			return 255 + $urandom_range(0, 12);
		return $urandom_range(0, 10);
	endfunction

	// Queue one well-formed sequence with random content
	function void gen_sequence();
		int unsigned lits, mlen, off, lim;
		logic [3:0] ln, mn;
		lits = ($urandom_range(0, 3) == 0) ? 15 + pick_ext() : $urandom_range(0, 14);
		if (gen_out == 0 && lits == 0)
			lits = 1;
		mlen = ($urandom_range(0, 4) == 0) ? 15 + pick_ext() : $urandom_range(0, 14);
		ln = (lits >= 15) ? 4'hF : 4'(lits);
		mn = (mlen >= 15) ? 4'hF : 4'(mlen);
		stream_q.push_back({ln, mn});
		if (lits >= 15)
			push_ext(lits - 15);
		repeat (lits) stream_q.push_back(8'($urandom));
		gen_out += lits;
		lim = (gen_out > 65535) ? 65535 : gen_out;
		off = $urandom_range(0, 1) ? $urandom_range(1, (lim < 16) ? lim : 16)
			: $urandom_range(1, lim);
		stream_q.push_back(off[7:0]);
		stream_q.push_back(off[15:8]);
		if (mlen >= 15)
			push_ext(mlen - 15);
		gen_out += mlen + 4;
	endfunction

	// Sample accepted result items
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check({out_valid, out_byte, consumed, done_res, status, out_count});
	end

	// Result side: random stalls, one long hold-off once the stream is busy
	initial begin
		bit held;
		int unsigned pct;
		held = 0;
		pct = 100;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sb.items >= 500) begin
				held = 1;
				res_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if ($urandom_range(0, 299) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				if ($urandom_range(0, 199) == 0)
					pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(30, 90);
				res_ready <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	initial begin
		#4ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		bit took;
		int unsigned ending;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		in_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = REG_INPUT_LENGTH;
		cfg_data = 32'd0;
		gen_out = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_INPUT_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_OUTPUT_CAPACITY, 32'hFFFF_FFFF);

		// Directed: extreme literals, overlapping match, literal-free sequence
		stream_q = '{8'h42, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h00,
			8'h07, 8'h04, 8'h00, 8'h0F, 8'h03, 8'h00, 8'hFF, 8'h02};
		gen_out = 4 + 6 + 11 + 15 + 255 + 2 + 4;
		play_stream();
		repeat (5) send_item(1'b1, 8'($urandom), 1, took);

		// Random sequences, with a settings change halfway
		while (sb.items < 850) begin
			gen_sequence();
			play_stream();
		end
		wait_idle();
		write_reg(REG_INPUT_LENGTH, 32'hFFFF_FFF0);
		write_reg(REG_OUTPUT_CAPACITY, sb.out_pos + 32'd1_000_000);
		while (sb.items < 1700) begin
			gen_sequence();
			play_stream();
		end
		// Drain a pending match with idle ticks
		while (sb.ph == PH_MATCH && !sb.fin)
			send_item(1'b1, 8'($urandom), 1, took);
		wait_idle();

		// Close the block one way, chosen at random
		ending = $urandom_range(0, 5);
		case (ending)
			0: begin
				write_reg(REG_INPUT_LENGTH, $urandom_range(0, 1) ? 32'd0 : sb.in_pos);
				stream_q = '{};
			end
			1: begin
				stream_q = '{8'h10, 8'($urandom)};
				if ($urandom_range(0, 1) || sb.out_pos > 65530) begin
					stream_q.push_back(8'h00);
					stream_q.push_back(8'h00);
				end else begin
					stream_q.push_back(8'(sb.out_pos + 2));
					stream_q.push_back(8'((sb.out_pos + 2) >> 8));
				end
			end
			2: begin
				write_reg(REG_INPUT_LENGTH, sb.in_pos + 32'd10);
				stream_q = '{8'hF0, 8'h01};
			end
			3: begin
				write_reg(REG_INPUT_LENGTH, sb.in_pos + 32'd8);
				stream_q = '{8'h1F, 8'h33, 8'h01, 8'h00, 8'h05};
			end
			4: begin
				write_reg(REG_OUTPUT_CAPACITY,
					($urandom_range(0, 3) == 0) ? 32'd0 : sb.out_pos + 32'd3);
				stream_q = '{8'h15, 8'h77, 8'h01, 8'h00};
			end
			default: begin
				write_reg(REG_INPUT_LENGTH, sb.in_pos + 32'd3);
				stream_q = '{8'h50, 8'h11, 8'h22, 8'h33};
			end
		endcase
		play_stream();
		// Items after the end are accepted but not consumed
		repeat (20) send_item(1'($urandom), 8'($urandom), 1, took);
		in_valid <= 1'b0;

		while (sb.expect_q.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
